// File: rtl/sfp_pkg.sv
// Shared constants and types for the sensor frame parser.
`default_nettype none
package sfp_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int FIX_BYTES   = 12;
  localparam int FIX_W       = $clog2(FIX_BYTES);
  localparam int LEN_W       = 7;

  localparam logic [7:0] HDR0     = 8'h53;
  localparam logic [7:0] HDR1     = 8'h59;
  localparam logic [7:0] TAIL0    = 8'h54;
  localparam logic [7:0] TAIL1    = 8'h43;
  localparam logic [7:0] CTRL_POS = 8'h80;
  localparam logic [7:0] CMD_POS  = 8'h05;
  localparam int         MIN_LEN  = 7;

  typedef enum logic [2:0] {
    ST_POSITION  = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_BAD_SUM   = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

endpackage
`default_nettype wire

// File: rtl/sensor_frame_parser.sv
// Sensor frame parser: header/tail framing, 8-bit sum check, position decode.
// A result is registered and appears in the cycle after the byte that ends its frame is taken.
// Throughput: one byte per cycle; a byte is taken whenever the result register
// is empty or being drained in the same cycle.
// Reset clears the byte count, running sum, frame bytes 0 to 11 and the
// result valid flag; the parser is ready in the first cycle after reset.
`default_nettype none
module sensor_frame_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rx_valid,
  output logic                  rx_ready,
  input  wire logic [7:0]       rx_byte,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output sfp_pkg::status_t      status,
  output logic signed [15:0]    pos_x,
  output logic signed [15:0]    pos_y,
  output logic signed [15:0]    pos_z,
  output logic [7:0]            calc_sum,
  output logic [7:0]            recv_sum,
  output logic [6:0]            frame_len
);
  import sfp_pkg::*;

  logic [CNT_W-1:0] count;
  logic [7:0]       acc;
  logic [7:0]       prev1;
  logic [7:0]       prev2;
  logic [7:0]       fixed [FIX_BYTES];
  logic [7:0]       view  [FIX_BYTES];

  logic             take;
  logic [CNT_W-1:0] n;
  logic             hdr_ok;
  logic             full;
  logic             tail_ok;
  logic             frame_done;
  logic             emit;
  logic [7:0]       sum_now;
  status_t          status_next;
  logic [15:0]      x_next;
  logic [15:0]      y_next;
  logic [15:0]      z_next;
  logic [7:0]       calc_next;
  logic [7:0]       recv_next;

  assign rx_ready = !res_valid || res_ready;
  assign take     = rx_valid && rx_ready;
  assign n        = count + CNT_W'(1);

  always_comb begin
    for (int i = 0; i < FIX_BYTES; i++) begin
      view[i] = (count == CNT_W'(i)) ? rx_byte : fixed[i];
    end
  end

  assign hdr_ok     = (n >= CNT_W'(2)) && (view[0] == HDR0) && (view[1] == HDR1);
  assign full       = (count == CNT_W'(STORE_DEPTH - 1));
  assign tail_ok    = (prev1 == TAIL0) && (rx_byte == TAIL1);
  assign frame_done = hdr_ok && (full || tail_ok);
  assign emit       = frame_done || full;
  assign sum_now    = acc - prev1 - prev2;

  always_comb begin
    status_next = ST_OVERFLOW;
    x_next      = '0;
    y_next      = '0;
    z_next      = '0;
    calc_next   = '0;
    recv_next   = '0;
    if (frame_done) begin
      if (n < CNT_W'(MIN_LEN)) begin
        status_next = ST_TOO_SHORT;
      end else begin
        calc_next = sum_now;
        recv_next = prev2;
        if (sum_now != prev2) begin
          status_next = ST_BAD_SUM;
        end else if (view[2] == CTRL_POS && view[3] == CMD_POS) begin
          status_next = ST_POSITION;
          x_next      = {view[6], view[7]};
          y_next      = {view[8], view[9]};
          z_next      = {view[10], view[11]};
        end else begin
          status_next = ST_UNKNOWN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      acc   <= '0;
      prev1 <= '0;
      prev2 <= '0;
      for (int i = 0; i < FIX_BYTES; i++) begin
        fixed[i] <= '0;
      end
    end else if (take) begin
      prev1 <= rx_byte;
      prev2 <= prev1;
      if (count < CNT_W'(FIX_BYTES)) begin
        fixed[count[FIX_W-1:0]] <= rx_byte;
      end
      if (emit) begin
        count <= '0;
        acc   <= '0;
      end else begin
        count <= n;
        if (count >= CNT_W'(2)) begin
          acc <= acc + rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      status    <= status_next;
      pos_x     <= x_next;
      pos_y     <= y_next;
      pos_z     <= z_next;
      calc_sum  <= calc_next;
      recv_sum  <= recv_next;
      frame_len <= n[LEN_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: rtl/sfp_checker.sv
// Port-level checks for the sensor frame parser, bound to the top level.
`default_nettype none
module sfp_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             rx_ready,
  input wire logic             res_valid,
  input wire logic             res_ready,
  input wire sfp_pkg::status_t status,
  input wire logic [15:0]      pos_x,
  input wire logic [7:0]       calc_sum,
  input wire logic [7:0]       recv_sum,
  input wire logic [6:0]       frame_len
);
  import sfp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(frame_len))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> rx_ready)
    else $error("request refused with empty result register");

  a_short: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_TOO_SHORT |->
      frame_len < 7'(MIN_LEN) && pos_x == 16'd0 && calc_sum == 8'd0)
    else $error("short frame result inconsistent");

  a_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_POSITION |->
      frame_len >= 7'(MIN_LEN) && calc_sum == recv_sum)
    else $error("position result without matching sum");

  a_ovf: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_OVERFLOW |->
      frame_len == 7'(STORE_DEPTH) && calc_sum == 8'd0 && recv_sum == 8'd0)
    else $error("overflow result inconsistent");

endmodule

bind sensor_frame_parser sfp_checker u_sfp_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_ready  (rx_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .status    (status),
  .pos_x     (pos_x),
  .calc_sum  (calc_sum),
  .recv_sum  (recv_sum),
  .frame_len (frame_len)
);
`default_nettype wire

// File: sim/tb_sensor_frame_parser.sv
// Testbench for the sensor frame parser: directed table, random frames, predicted results.
module tb_sensor_frame_parser;
  import sfp_pkg::*;

  localparam int DIR_ROWS = 40;
  localparam int RAND_ITEMS = 1100;
  localparam int QUIET_AT = DIR_ROWS + RAND_ITEMS - 150;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [7:0]         csum;
    logic [7:0]         rsum;
    logic [6:0]         len;
  } frame_res_t;

  typedef struct packed {
    logic [7:0] row;
    frame_res_t res;
  } known_res_t;

  localparam logic [7:0] DIR_BYTES [DIR_ROWS] = '{
    8'h53, 8'h59, 8'h54, 8'h43,
    8'h53, 8'h59, 8'h80, 8'h05, 8'h00, 8'h00, 8'h80, 8'h00,
    8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h81, 8'h54, 8'h43,
    8'h53, 8'h59, 8'h80, 8'h05, 8'h85, 8'h54, 8'h43,
    8'h53, 8'h59, 8'h12, 8'h34, 8'h00, 8'h54, 8'h43,
    8'h53, 8'h59, 8'h12, 8'h34, 8'h46, 8'h54, 8'h43
  };

  localparam known_res_t KNOWN_RES [4] = '{
    '{8'd3,  '{ST_TOO_SHORT, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 7'd4}},
    '{8'd18, '{ST_POSITION,  16'h8000, 16'h7FFF, 16'hFFFF, 8'h81, 8'h81, 7'd15}},
    '{8'd32, '{ST_BAD_SUM,   16'h0000, 16'h0000, 16'h0000, 8'h46, 8'h00, 7'd7}},
    '{8'd39, '{ST_UNKNOWN,   16'h0000, 16'h0000, 16'h0000, 8'h46, 8'h46, 7'd7}}
  };

  logic               clk;
  logic               rst = 1'b1;
  logic               rx_valid = 1'b0;
  logic               rx_ready;
  logic [7:0]         rx_byte = 8'h00;
  logic               res_valid;
  logic               res_ready = 1'b0;
  status_t            status;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [7:0]         calc_sum;
  logic [7:0]         recv_sum;
  logic [6:0]         frame_len;

  logic [7:0]  frame_mem [STORE_DEPTH];
  int unsigned frame_cnt = 0;
  frame_res_t  res_q [$];
  int          fail_cnt = 0;
  int          sent_cnt = 0;
  bit          idle_en = 1'b0;
  bit          quiet = 1'b0;
  bit          hold_off = 1'b0;
  int          stall_left = 0;
  int          calm_left = 0;

  sensor_frame_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .status    (status),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .calc_sum  (calc_sum),
    .recv_sum  (recv_sum),
    .frame_len (frame_len)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic bit parse_byte(input logic [7:0] b, output frame_res_t r);
    int         n;
    int         i;
    logic [7:0] s;
    r = '0;
    if (frame_cnt >= STORE_DEPTH) frame_cnt = 0;
    frame_mem[frame_cnt] = b;
    frame_cnt++;
    n = frame_cnt;
    if (n >= 2 && frame_mem[0] == HDR0 && frame_mem[1] == HDR1 &&
        (n >= STORE_DEPTH || (frame_mem[n-2] == TAIL0 && frame_mem[n-1] == TAIL1))) begin
      frame_cnt = 0;
      r.len = n[6:0];
      if (n < MIN_LEN) begin
        r.status = ST_TOO_SHORT;
        return 1'b1;
      end
      s = 8'h00;
      for (i = 2; i + 3 < n; i++) s += frame_mem[i];
      r.csum = s;
      r.rsum = frame_mem[n-3];
      if (s != frame_mem[n-3]) begin
        r.status = ST_BAD_SUM;
      end else if (frame_mem[2] == CTRL_POS && frame_mem[3] == CMD_POS) begin
        r.status = ST_POSITION;
        r.x = {frame_mem[6], frame_mem[7]};
        r.y = {frame_mem[8], frame_mem[9]};
        r.z = {frame_mem[10], frame_mem[11]};
      end else begin
        r.status = ST_UNKNOWN;
      end
      return 1'b1;
    end
    if (n >= STORE_DEPTH) begin
      frame_cnt = 0;
      r.status = ST_OVERFLOW;
      r.len = n[6:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!rx_ready);
    sent_cnt++;
  endtask

  task automatic feed(input logic [7:0] b);
    frame_res_t r;
    send_byte(b);
    if (parse_byte(b, r)) res_q.push_back(r);
  endtask

  task automatic run_sequence();
    logic [7:0] seq [STORE_DEPTH];
    int         n;
    int         kind;
    int         j;
    logic [7:0] s;
    bit         clash;
    if (sent_cnt >= QUIET_AT) quiet <= 1'b1;
    idle_en = (sent_cnt < QUIET_AT) && ($urandom_range(0, 3) != 0);
    kind = $urandom_range(0, 99);
    if (kind >= 92) begin
      // cut a frame short and start a fresh one inside it
      feed(HDR0);
      feed(HDR1);
      repeat ($urandom_range(0, 6)) feed(8'($urandom_range(0, 255)));
      kind = $urandom_range(0, 85);
    end
    if (kind >= 86) begin
      do feed(8'($urandom_range(0, 255))); while (frame_cnt != 0);
    end else begin
      if (kind >= 80) n = STORE_DEPTH;
      else if (kind >= 70) n = $urandom_range(4, 6);
      else if ($urandom_range(0, 7) == 0) n = $urandom_range(7, 40);
      else n = $urandom_range(7, 16);
      do begin
        seq[0] = HDR0;
        seq[1] = HDR1;
        for (j = 2; j < n; j++) seq[j] = 8'($urandom_range(0, 255));
        if (n >= MIN_LEN) begin
          if (kind < 45 || (kind >= 80 && kind < 83) ||
              (kind >= 60 && kind < 70 && $urandom_range(0, 1) == 1)) begin
            seq[2] = CTRL_POS;
            seq[3] = CMD_POS;
          end else if (kind >= 45 && kind < 60) begin
            if ($urandom_range(0, 1) == 1) seq[2] = CTRL_POS;
            if (seq[2] == CTRL_POS && seq[3] == CMD_POS) seq[3] = ~CMD_POS;
          end
          s = 8'h00;
          for (j = 2; j + 3 < n; j++) s += seq[j];
          if (kind >= 60 && kind < 70) seq[n-3] = s ^ 8'($urandom_range(1, 255));
          else if (kind < 83) seq[n-3] = s;
        end
        if (n < STORE_DEPTH) begin
          seq[n-2] = TAIL0;
          seq[n-1] = TAIL1;
        end
        clash = 1'b0;
        for (j = 2; j < n - 1; j++) begin
          if (seq[j-1] == TAIL0 && seq[j] == TAIL1) clash = 1'b1;
        end
      end while (clash);
      for (j = 0; j < n; j++) feed(seq[j]);
    end
    while (frame_cnt != 0) feed(8'($urandom_range(0, 255)));
  endtask

  task automatic note_fail(input string what, input frame_res_t want, input frame_res_t got);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%s: expected st=%0d x=%0d y=%0d z=%0d cs=%h rs=%h len=%0d",
               what, want.status, want.x, want.y, want.z, want.csum, want.rsum, want.len);
      $display("  actual st=%0d x=%0d y=%0d z=%0d cs=%h rs=%h len=%0d",
               got.status, got.x, got.y, got.z, got.csum, got.rsum, got.len);
    end
  endtask

  task automatic check_result();
    frame_res_t want;
    frame_res_t got;
    got.status = status;
    got.x = pos_x;
    got.y = pos_y;
    got.z = pos_z;
    got.csum = calc_sum;
    got.rsum = recv_sum;
    got.len = frame_len;
    if (res_q.size() == 0) begin
      note_fail("result with no frame pending", '0, got);
    end else begin
      want = res_q.pop_front();
      if (got.status !== want.status || got.x !== want.x || got.y !== want.y ||
          got.z !== want.z || got.csum !== want.csum || got.rsum !== want.rsum ||
          got.len !== want.len) begin
        note_fail("result mismatch", want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) check_result();
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        res_ready  <= 1'b0;
        if (stall_left == 1 && $urandom_range(0, 3) == 0) calm_left <= $urandom_range(20, 80);
      end else if (!quiet && calm_left == 0 && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(1, 19) - 1;
        res_ready  <= 1'b0;
      end else begin
        if (calm_left != 0) calm_left <= calm_left - 1;
        res_ready <= !hold_off;
      end
    end
  end

  // hold the result side off long enough to back up the input
  initial begin
    wait (sent_cnt >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int         row;
    int         k;
    frame_res_t r;
    bit         has_res;
    for (row = 0; row < STORE_DEPTH; row++) frame_mem[row] = 8'h00;
    k = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (row = 0; row < DIR_ROWS; row++) begin
      idle_en = ($urandom_range(0, 1) == 1);
      send_byte(DIR_BYTES[row]);
      has_res = parse_byte(DIR_BYTES[row], r);
      if (k < 4 && KNOWN_RES[k].row == row) begin
        res_q.push_back(KNOWN_RES[k].res);
        k++;
      end else if (has_res) begin
        res_q.push_back(r);
      end
    end
    while (sent_cnt < DIR_ROWS + RAND_ITEMS) run_sequence();
    rx_valid <= 1'b0;
    while (res_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
